/* hw/rtl/cstm_pkg.sv */
// Shared types and constants for the compose-sequence trie matcher.
// Used by cstm_ctrl, cstm_dp and compose_sequence_trie_matcher; no dependencies.
package cstm_pkg;

	localparam int NODE_DEPTH = 4096;
	localparam int TEXT_SPACE = 65536;

	localparam int ADDR_W   = $clog2(NODE_DEPTH);
	localparam int STEP_W   = $clog2(NODE_DEPTH + 1);
	localparam int KEY_W    = 29;
	localparam int TEXT_W   = 16;
	localparam int PAY_W    = KEY_W + TEXT_W;
	localparam int CNT_W    = 13;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W    = 29;
	localparam int IN_W     = 128;
	localparam int OUT_W    = 56;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_FEED  = 2'd1,
		OP_RESET = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		FR_IGNORED  = 2'd0,
		FR_ACCEPTED = 2'd1,
		FR_NOT_FEED = 2'd2
	} feed_res_t;

	typedef enum logic [1:0] {
		STS_NOTHING   = 2'd0,
		STS_COMPOSING = 2'd1,
		STS_COMPOSED  = 2'd2,
		STS_CANCELLED = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NODE_COUNT   = 3'd0,
		CFG_MOD_A_LOW    = 3'd1,
		CFG_MOD_A_HIGH   = 3'd2,
		CFG_MOD_B_LOW    = 3'd3,
		CFG_MOD_B_HIGH   = 3'd4,
		CFG_MOD_SINGLE_A = 3'd5,
		CFG_MOD_SINGLE_B = 3'd6
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_FEED_START,
		S_WALK,
		S_WALK_CMP,
		S_COMMIT,
		S_STAT_A,
		S_STAT_B,
		S_STAT_C
	} state_t;

	typedef enum logic [1:0] {
		RD_POS,
		RD_PREV,
		RD_CTX
	} rd_sel_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
		logic              leaf;
		logic [PAY_W-1:0]  pay;
	} node_t;

	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key;
		logic [ADDR_W-1:0] index;
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
		logic              leaf;
		logic [ADDR_W-1:0] next_level;
		logic [TEXT_W-1:0] text;
		logic [KEY_W-1:0]  sym;
	} item_t;

	typedef struct packed {
		logic    cap_item;
		logic    decode;
		logic    node_wr;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    walk_init;
		logic    walk_step;
		logic    walk_cmp;
		logic    walk_abort;
		logic    pos_commit;
		logic    pos_clear;
		logic    prev_latch;
		logic    out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic is_mod;
		logic ctx_zero;
		logic steps_full;
		logic key_eq;
	} dp_stat_t;

endpackage

/* hw/rtl/cstm_ctrl.sv */
// Sequencer for the trie matcher: decodes items, steps the sibling walk,
// runs the status reads and owns both handshakes. Depends on cstm_pkg.
module cstm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  cstm_pkg::dp_stat_t   stat,
	output cstm_pkg::ctrl_cmd_t  cmd
);

	cstm_pkg::state_t state_q;
	cstm_pkg::state_t state_nxt;
	logic             m_tvalid_q;

	assign s_tready = (state_q == cstm_pkg::S_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cstm_pkg::S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			cstm_pkg::S_IDLE: begin
				if (s_tvalid) begin
					cmd.cap_item = 1'b1;
					state_nxt    = cstm_pkg::S_DECODE;
				end
			end
			cstm_pkg::S_DECODE: begin
				cmd.decode = 1'b1;
				state_nxt  = cstm_pkg::S_STAT_A;
				unique case (stat.op)
					cstm_pkg::OP_LOAD:  cmd.node_wr = 1'b1;
					cstm_pkg::OP_FEED: begin
						if (!stat.is_mod) begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = cstm_pkg::RD_POS;
							state_nxt  = cstm_pkg::S_FEED_START;
						end
					end
					cstm_pkg::OP_RESET: cmd.pos_clear = 1'b1;
					cstm_pkg::OP_NOP:   ;
				endcase
			end
			cstm_pkg::S_FEED_START: begin
				cmd.walk_init = 1'b1;
				state_nxt     = cstm_pkg::S_WALK;
			end
			cstm_pkg::S_WALK: begin
				if (stat.ctx_zero) begin
					state_nxt = cstm_pkg::S_COMMIT;
				end else if (stat.steps_full) begin
					cmd.walk_abort = 1'b1;
					state_nxt      = cstm_pkg::S_COMMIT;
				end else begin
					cmd.walk_step = 1'b1;
					cmd.rd_en     = 1'b1;
					cmd.rd_sel    = cstm_pkg::RD_CTX;
					state_nxt     = cstm_pkg::S_WALK_CMP;
				end
			end
			cstm_pkg::S_WALK_CMP: begin
				cmd.walk_cmp = 1'b1;
				state_nxt    = stat.key_eq ? cstm_pkg::S_COMMIT : cstm_pkg::S_WALK;
			end
			cstm_pkg::S_COMMIT: begin
				cmd.pos_commit = 1'b1;
				state_nxt      = cstm_pkg::S_STAT_A;
			end
			cstm_pkg::S_STAT_A: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = cstm_pkg::RD_PREV;
				state_nxt  = cstm_pkg::S_STAT_B;
			end
			cstm_pkg::S_STAT_B: begin
				cmd.prev_latch = 1'b1;
				cmd.rd_en      = 1'b1;
				cmd.rd_sel     = cstm_pkg::RD_POS;
				state_nxt      = cstm_pkg::S_STAT_C;
			end
			cstm_pkg::S_STAT_C: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_nxt    = cstm_pkg::S_IDLE;
				end
			end
			default: state_nxt = cstm_pkg::S_IDLE;
		endcase
	end

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == cstm_pkg::S_DECODE && !s_tready))
		else $error("accepted item did not enter decode");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (m_tvalid_q && state_q == cstm_pkg::S_IDLE))
		else $error("result load did not raise valid");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |-> !cmd.out_load)
		else $error("pending result overwritten");

	a_wr_rd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.node_wr && cmd.rd_en))
		else $error("node write and read in same cycle");

endmodule

/* hw/rtl/cstm_dp.sv */
// Datapath of the trie matcher: node memory, configuration registers,
// walk and position registers, result register. Depends on cstm_pkg.
module cstm_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cstm_pkg::item_t                in_item,
	input  logic                           cfg_we,
	input  logic [cstm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cstm_pkg::CFG_W-1:0]     cfg_data,
	input  cstm_pkg::ctrl_cmd_t            cmd,
	output cstm_pkg::dp_stat_t             stat,
	output logic [cstm_pkg::OUT_W-1:0]     out_data
);

	cstm_pkg::node_t node_mem_q [cstm_pkg::NODE_DEPTH];
	cstm_pkg::node_t rd_q;
	cstm_pkg::node_t wr_node;
	cstm_pkg::item_t item_q;

	logic [cstm_pkg::CNT_W-1:0]  node_count_q;
	logic [cstm_pkg::KEY_W-1:0]  mod_a_lo_q, mod_a_hi_q, mod_b_lo_q, mod_b_hi_q;
	logic [cstm_pkg::KEY_W-1:0]  mod_sa_q, mod_sb_q;

	logic [cstm_pkg::ADDR_W-1:0] pos_q, prev_q, ctx_q, ctx_start, rd_addr;
	logic [cstm_pkg::STEP_W-1:0] steps_q;
	logic                        prev_leaf_q;
	cstm_pkg::feed_res_t         fr_q;
	logic [cstm_pkg::OUT_W-1:0]  out_q;
	logic [cstm_pkg::TEXT_W-1:0] wr_text;
	cstm_pkg::status_t           sts;
	logic [cstm_pkg::KEY_W-1:0]  res_sym;
	logic [cstm_pkg::TEXT_W-1:0] res_text;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= cstm_pkg::CNT_W'(1);
			mod_a_lo_q   <= cstm_pkg::KEY_W'(65505);
			mod_a_hi_q   <= cstm_pkg::KEY_W'(65518);
			mod_b_lo_q   <= cstm_pkg::KEY_W'(65025);
			mod_b_hi_q   <= cstm_pkg::KEY_W'(65043);
			mod_sa_q     <= cstm_pkg::KEY_W'(65406);
			mod_sb_q     <= cstm_pkg::KEY_W'(65407);
		end else if (cfg_we) begin
			case (cfg_index)
				cstm_pkg::CFG_NODE_COUNT:   node_count_q <= cfg_data[cstm_pkg::CNT_W-1:0];
				cstm_pkg::CFG_MOD_A_LOW:    mod_a_lo_q   <= cfg_data;
				cstm_pkg::CFG_MOD_A_HIGH:   mod_a_hi_q   <= cfg_data;
				cstm_pkg::CFG_MOD_B_LOW:    mod_b_lo_q   <= cfg_data;
				cstm_pkg::CFG_MOD_B_HIGH:   mod_b_hi_q   <= cfg_data;
				cstm_pkg::CFG_MOD_SINGLE_A: mod_sa_q     <= cfg_data;
				cstm_pkg::CFG_MOD_SINGLE_B: mod_sb_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_item) begin
			item_q <= in_item;
		end
	end

	// text offsets outside the text space are stored as none
	assign wr_text = ({1'b0, item_q.text} >= (cstm_pkg::TEXT_W + 1)'(cstm_pkg::TEXT_SPACE))
		? '0 : item_q.text;

	always_comb begin
		wr_node.key  = item_q.key;
		wr_node.lo   = item_q.lo;
		wr_node.hi   = item_q.hi;
		wr_node.leaf = item_q.leaf;
		if (item_q.leaf) begin
			wr_node.pay = {item_q.sym, wr_text};
		end else begin
			wr_node.pay = cstm_pkg::PAY_W'(item_q.next_level);
		end
	end

	always_comb begin
		unique case (cmd.rd_sel)
			cstm_pkg::RD_POS:  rd_addr = pos_q;
			cstm_pkg::RD_PREV: rd_addr = prev_q;
			cstm_pkg::RD_CTX:  rd_addr = ctx_q;
			default:           rd_addr = pos_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.node_wr) begin
			node_mem_q[item_q.index] <= wr_node;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= node_mem_q[rd_addr];
		end
	end

	always_comb begin
		ctx_start = rd_q.leaf ? cstm_pkg::ADDR_W'(1) : rd_q.pay[cstm_pkg::ADDR_W-1:0];
		if (ctx_start == cstm_pkg::ADDR_W'(1) && node_count_q == cstm_pkg::CNT_W'(1)) begin
			ctx_start = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q       <= '0;
			steps_q     <= '0;
			pos_q       <= '0;
			prev_q      <= '0;
			prev_leaf_q <= 1'b0;
			fr_q        <= cstm_pkg::FR_NOT_FEED;
		end else begin
			if (cmd.decode) begin
				if (item_q.op != cstm_pkg::OP_FEED) begin
					fr_q <= cstm_pkg::FR_NOT_FEED;
				end else if (stat.is_mod) begin
					fr_q <= cstm_pkg::FR_IGNORED;
				end else begin
					fr_q <= cstm_pkg::FR_ACCEPTED;
				end
			end
			if (cmd.walk_init) begin
				ctx_q   <= ctx_start;
				steps_q <= '0;
			end else if (cmd.walk_step) begin
				steps_q <= steps_q + cstm_pkg::STEP_W'(1);
			end else if (cmd.walk_abort) begin
				ctx_q <= '0;
			end else if (cmd.walk_cmp && !stat.key_eq) begin
				ctx_q <= (item_q.key < rd_q.key) ? rd_q.lo : rd_q.hi;
			end
			if (cmd.pos_clear) begin
				pos_q  <= '0;
				prev_q <= '0;
			end else if (cmd.pos_commit) begin
				prev_q <= pos_q;
				pos_q  <= ctx_q;
			end
			if (cmd.prev_latch) begin
				prev_leaf_q <= rd_q.leaf;
			end
		end
	end

	assign stat.op         = item_q.op;
	assign stat.is_mod     = (item_q.key >= mod_a_lo_q && item_q.key <= mod_a_hi_q)
		|| (item_q.key >= mod_b_lo_q && item_q.key <= mod_b_hi_q)
		|| item_q.key == mod_sa_q || item_q.key == mod_sb_q;
	assign stat.ctx_zero   = (ctx_q == '0);
	assign stat.steps_full = (steps_q == cstm_pkg::STEP_W'(cstm_pkg::NODE_DEPTH));
	assign stat.key_eq     = (item_q.key == rd_q.key);

	// rd_q holds the node at the current position here
	always_comb begin
		res_sym  = '0;
		res_text = '0;
		if (pos_q == '0) begin
			sts = prev_leaf_q ? cstm_pkg::STS_NOTHING : cstm_pkg::STS_CANCELLED;
		end else if (!rd_q.leaf) begin
			sts = cstm_pkg::STS_COMPOSING;
		end else begin
			sts      = cstm_pkg::STS_COMPOSED;
			res_text = rd_q.pay[cstm_pkg::TEXT_W-1:0];
			res_sym  = rd_q.pay[cstm_pkg::PAY_W-1:cstm_pkg::TEXT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= cstm_pkg::OUT_W'({res_text, res_sym, sts, fr_q});
		end
	end

	assign out_data = out_q;

	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= cstm_pkg::STEP_W'(cstm_pkg::NODE_DEPTH))
		else $error("walk step count past table depth");

	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pos_clear |=> (pos_q == '0 && prev_q == '0))
		else $error("position not cleared");

endmodule

/* hw/rtl/compose_sequence_trie_matcher.sv */
// Top level of the compose-sequence trie matcher.
// Instantiates cstm_ctrl and cstm_dp; depends on cstm_pkg.
// Usage:
//   s_* channel carries one item per transfer: s_tuser is the op (load node,
//   feed keysym, reset position, no-op), s_tdata the keysym and node fields.
//   m_* channel returns exactly one result per item: feed result, status,
//   composed keysym and text offset. cfg_we/cfg_index/cfg_data write
//   node_count and the modifier keysyms; write only while no item is in flight.
// Sequencing:
//   One item at a time. Load, reset, no-op and modifier feeds pass from decode
//   through STAT_A, STAT_B and STAT_C, where the result is loaded.
//   A feed walks the trie after decode; the walk ends on a match, a zero link
//   or the 4096-step limit, and each visit of a trie node is one read of the
//   single node memory port followed by a compare step.
// Reset:
//   arst_n clears position and handshake state and loads configuration
//   defaults. The node memory is not cleared; nodes must be loaded before use.
// Backpressure:
//   One result is held in the output register while m_tready is low; the
//   next item is accepted and processed, then waits until that slot frees.
module compose_sequence_trie_matcher (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// keysym[28:0], node_index[40:29], node_lo[52:41], node_hi[64:53],
	// node_is_leaf[65], node_next_level[77:66], node_text_offset[93:78],
	// node_result_sym[122:94], zero fill above
	input  logic [cstm_pkg::IN_W-1:0]          s_tdata,
	// op[1:0]
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// feed_result[1:0], status[3:2], composed_sym[32:4], composed_text[48:33],
	// zero fill above
	output logic [cstm_pkg::OUT_W-1:0]         m_tdata,
	input  logic                               cfg_we,
	input  logic [cstm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cstm_pkg::CFG_W-1:0]         cfg_data
);

	cstm_pkg::item_t     in_item;
	cstm_pkg::ctrl_cmd_t cmd;
	cstm_pkg::dp_stat_t  stat;

	assign in_item.op         = cstm_pkg::op_t'(s_tuser);
	assign in_item.key        = s_tdata[28:0];
	assign in_item.index      = s_tdata[40:29];
	assign in_item.lo         = s_tdata[52:41];
	assign in_item.hi         = s_tdata[64:53];
	assign in_item.leaf       = s_tdata[65];
	assign in_item.next_level = s_tdata[77:66];
	assign in_item.text       = s_tdata[93:78];
	assign in_item.sym        = s_tdata[122:94];

	cstm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cstm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_tdata)
	);

endmodule

/* sim/tb.sv */
// Testbench for compose_sequence_trie_matcher: loads small ternary tries, feeds keysym
// sequences and compares every result with a trie walker kept inside the bench.
// Depends on cstm_pkg and the matcher RTL; drives the stream, config and reset ports.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [cstm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	localparam logic [cstm_pkg::KEY_W-1:0] KEY_MAX = '1;

	typedef struct packed {
		cstm_pkg::feed_res_t         fr;
		cstm_pkg::status_t           st;
		logic [cstm_pkg::KEY_W-1:0]  sym;
		logic [cstm_pkg::TEXT_W-1:0] text;
	} outcome_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [cstm_pkg::IN_W-1:0]      s_tdata = '0;
	logic [1:0]                     s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [cstm_pkg::OUT_W-1:0]     m_tdata;
	logic                           cfg_we = 1'b0;
	logic [cstm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [cstm_pkg::CFG_W-1:0]     cfg_data = '0;

	compose_sequence_trie_matcher uut (.*);

	// trie image and matcher position as the bench sees them
	logic [cstm_pkg::KEY_W-1:0]  trie_key [cstm_pkg::NODE_DEPTH];
	logic [cstm_pkg::ADDR_W-1:0] trie_lo [cstm_pkg::NODE_DEPTH];
	logic [cstm_pkg::ADDR_W-1:0] trie_hi [cstm_pkg::NODE_DEPTH];
	logic                        trie_leaf [cstm_pkg::NODE_DEPTH];
	logic [cstm_pkg::PAY_W-1:0]  trie_pay [cstm_pkg::NODE_DEPTH];
	logic [cstm_pkg::ADDR_W-1:0] cur_node, last_node;
	logic [cstm_pkg::CNT_W-1:0]  cfg_nodes;
	logic [cstm_pkg::KEY_W-1:0]  mod_a_lo, mod_a_hi, mod_b_lo, mod_b_hi, mod_one, mod_two;

	cstm_pkg::item_t item_backlog[$];
	outcome_t        due_results[$];
	cstm_pkg::item_t cur_item;
	outcome_t        head_result;
	int              pool[$];
	logic            in_pool [cstm_pkg::NODE_DEPTH];
	logic [cstm_pkg::KEY_W-1:0] key_base;

	int idle_pct = 8;
	int send_gap = 0;
	int rcv_gap = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int results_seen = 0;
	int errors = 0;
	int worth = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic bit is_mod(logic [cstm_pkg::KEY_W-1:0] k);
		return (k >= mod_a_lo && k <= mod_a_hi) || (k >= mod_b_lo && k <= mod_b_hi) ||
			k == mod_one || k == mod_two;
	endfunction

	task automatic trie_step(input cstm_pkg::item_t it);
		logic [cstm_pkg::ADDR_W-1:0] ctx;
		int steps;
		bit found;
		outcome_t res;
		res.fr = cstm_pkg::FR_NOT_FEED;
		res.st = cstm_pkg::STS_NOTHING;
		res.sym = '0;
		res.text = '0;
		case (it.op)
			cstm_pkg::OP_LOAD: begin
				trie_key[it.index] = it.key;
				trie_lo[it.index] = it.lo;
				trie_hi[it.index] = it.hi;
				trie_leaf[it.index] = it.leaf;
				trie_pay[it.index] = it.leaf ? {it.sym, it.text} :
					cstm_pkg::PAY_W'(it.next_level);
			end
			cstm_pkg::OP_FEED: begin
				if (is_mod(it.key)) begin
					res.fr = cstm_pkg::FR_IGNORED;
				end else begin
					res.fr = cstm_pkg::FR_ACCEPTED;
					ctx = trie_leaf[cur_node] ? cstm_pkg::ADDR_W'(1) :
						trie_pay[cur_node][cstm_pkg::ADDR_W-1:0];
					if (ctx == 1 && cfg_nodes == 1)
						ctx = '0;
					steps = 0;
					found = 1'b0;
					while (ctx != 0 && !found) begin
						if (steps >= cstm_pkg::NODE_DEPTH) begin
							ctx = '0;
						end else begin
							steps++;
							if (it.key < trie_key[ctx])
								ctx = trie_lo[ctx];
							else if (it.key > trie_key[ctx])
								ctx = trie_hi[ctx];
							else
								found = 1'b1;
						end
					end
					last_node = cur_node;
					cur_node = ctx;
				end
			end
			cstm_pkg::OP_RESET: begin
				cur_node = '0;
				last_node = '0;
			end
			default: ;
		endcase
		if (cur_node == 0 && !trie_leaf[last_node]) begin
			res.st = cstm_pkg::STS_CANCELLED;
		end else if (cur_node == 0) begin
			res.st = cstm_pkg::STS_NOTHING;
		end else if (!trie_leaf[cur_node]) begin
			res.st = cstm_pkg::STS_COMPOSING;
		end else begin
			res.st = cstm_pkg::STS_COMPOSED;
			res.sym = trie_pay[cur_node][cstm_pkg::PAY_W-1:cstm_pkg::TEXT_W];
			res.text = trie_pay[cur_node][cstm_pkg::TEXT_W-1:0];
		end
		due_results.push_back(res);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready)
				trie_step(cur_item);
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					s_tvalid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (item_backlog.size() != 0) begin
					cur_item = item_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= cstm_pkg::IN_W'({cur_item.sym, cur_item.text,
						cur_item.next_level, cur_item.leaf, cur_item.hi, cur_item.lo,
						cur_item.index, cur_item.key});
					s_tuser <= cur_item.op;
					if ($urandom_range(0, 99) < idle_pct)
						send_gap <= $urandom_range(1, 19);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rcv_gap <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (due_results.size() == 0) begin
					report_mismatch("unexpected result", m_tdata[48:0], 0);
				end else begin
					head_result = due_results.pop_front();
					if (m_tdata[1:0] != head_result.fr)
						report_mismatch("feed_result", m_tdata[1:0], head_result.fr);
					if (m_tdata[3:2] != head_result.st)
						report_mismatch("status", m_tdata[3:2], head_result.st);
					if (m_tdata[32:4] != head_result.sym)
						report_mismatch("composed_sym", m_tdata[32:4], head_result.sym);
					if (m_tdata[48:33] != head_result.text)
						report_mismatch("composed_text", m_tdata[48:33], head_result.text);
				end
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!hold_done && results_seen >= 300 && s_tvalid) begin
				// long back-pressure so the input side fills and stalls
				hold_done <= 1'b1;
				hold_left <= 400;
				m_tready <= 1'b0;
			end else if (rcv_gap > 0) begin
				m_tready <= 1'b0;
				rcv_gap <= rcv_gap - 1;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				m_tready <= 1'b0;
				rcv_gap <= $urandom_range(0, 18);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic cstm_pkg::item_t loose_item(cstm_pkg::op_t op,
		logic [cstm_pkg::KEY_W-1:0] k);
		cstm_pkg::item_t it;
		logic [$bits(cstm_pkg::item_t)-1:0] raw;
		raw = $bits(cstm_pkg::item_t)'({$urandom(), $urandom(), $urandom(), $urandom()});
		it = raw;
		it.op = op;
		it.key = k;
		return it;
	endfunction

	function automatic cstm_pkg::item_t node_item(int at, logic [cstm_pkg::KEY_W-1:0] k,
		int lo, int hi, bit leaf, int nxt, logic [cstm_pkg::TEXT_W-1:0] text,
		logic [cstm_pkg::KEY_W-1:0] sym);
		cstm_pkg::item_t it;
		it.op = cstm_pkg::OP_LOAD;
		it.key = k;
		it.index = cstm_pkg::ADDR_W'(at);
		it.lo = cstm_pkg::ADDR_W'(lo);
		it.hi = cstm_pkg::ADDR_W'(hi);
		it.leaf = leaf;
		it.next_level = cstm_pkg::ADDR_W'(nxt);
		it.text = text;
		it.sym = sym;
		return it;
	endfunction

	function automatic logic [cstm_pkg::KEY_W-1:0] pick_key();
		if ($urandom_range(0, 9) == 0)
			return cstm_pkg::KEY_W'($urandom());
		return key_base + cstm_pkg::KEY_W'($urandom_range(0, 7));
	endfunction

	// sibling links only point forward in the pool, so walks cannot loop
	function automatic logic [cstm_pkg::ADDR_W-1:0] pick_link(int ppos);
		if (ppos >= pool.size() - 1 || $urandom_range(0, 2) == 0)
			return '0;
		return cstm_pkg::ADDR_W'(pool[$urandom_range(ppos + 1, pool.size() - 1)]);
	endfunction

	// ppos < 0: node outside the pool, never reached, so its links are free
	function automatic cstm_pkg::item_t make_node(int at, int ppos);
		cstm_pkg::item_t it;
		it = loose_item(cstm_pkg::OP_LOAD, pick_key());
		it.index = cstm_pkg::ADDR_W'(at);
		it.leaf = ($urandom_range(0, 2) == 0);
		if (ppos >= 0) begin
			it.lo = pick_link(ppos);
			it.hi = pick_link(ppos);
			it.next_level = ($urandom_range(0, 5) == 0) ? '0 :
				cstm_pkg::ADDR_W'(pool[$urandom_range(0, pool.size() - 1)]);
		end
		if ($urandom_range(0, 4) == 0)
			it.sym = '0;
		if ($urandom_range(0, 4) == 0)
			it.text = '0;
		return it;
	endfunction

	function automatic logic [cstm_pkg::KEY_W-1:0] pick_feed_key();
		case ($urandom_range(0, 19))
			0: return mod_one;
			1: return mod_b_hi;
			2: return mod_a_lo;
			3: return cstm_pkg::KEY_W'($urandom());
			default: return key_base + cstm_pkg::KEY_W'($urandom_range(0, 7));
		endcase
	endfunction

	task automatic queue_item(cstm_pkg::item_t it);
		item_backlog.push_back(it);
		worth++;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (item_backlog.size() != 0 || s_tvalid || due_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [cstm_pkg::CFG_IDX_W-1:0] idx,
		logic [cstm_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			cstm_pkg::CFG_NODE_COUNT:   cfg_nodes = val[cstm_pkg::CNT_W-1:0];
			cstm_pkg::CFG_MOD_A_LOW:    mod_a_lo = val;
			cstm_pkg::CFG_MOD_A_HIGH:   mod_a_hi = val;
			cstm_pkg::CFG_MOD_B_LOW:    mod_b_lo = val;
			cstm_pkg::CFG_MOD_B_HIGH:   mod_b_hi = val;
			cstm_pkg::CFG_MOD_SINGLE_A: mod_one = val;
			cstm_pkg::CFG_MOD_SINGLE_B: mod_two = val;
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(int mode);
		logic [cstm_pkg::KEY_W-1:0] cnt, alo, ahi, blo, bhi, s1, s2;
		case (mode)
			0: begin
				cnt = cstm_pkg::NODE_DEPTH;
				alo = 65505;
				ahi = 65518;
				blo = 65025;
				bhi = 65043;
				s1 = 65406;
				s2 = 65407;
			end
			1: begin
				// every keysym is a modifier
				cnt = cstm_pkg::NODE_DEPTH;
				alo = '0;
				ahi = KEY_MAX;
				blo = '0;
				bhi = '0;
				s1 = '0;
				s2 = KEY_MAX;
			end
			2: begin
				// single-node table, empty ranges
				cnt = 1;
				alo = KEY_MAX;
				ahi = '0;
				blo = KEY_MAX;
				bhi = 1;
				s1 = KEY_MAX;
				s2 = '0;
			end
			default: begin
				cnt = $urandom_range(2, cstm_pkg::NODE_DEPTH);
				if ($urandom_range(0, 1) == 0) begin
					alo = key_base + 7;
					ahi = alo + cstm_pkg::KEY_W'($urandom_range(0, 3));
				end else begin
					alo = cstm_pkg::KEY_W'($urandom());
					ahi = alo + cstm_pkg::KEY_W'($urandom_range(0, 5000));
				end
				blo = cstm_pkg::KEY_W'($urandom());
				bhi = blo + cstm_pkg::KEY_W'($urandom());
				s1 = ($urandom_range(0, 2) == 0) ?
					key_base + cstm_pkg::KEY_W'($urandom_range(0, 7)) :
					cstm_pkg::KEY_W'($urandom());
				s2 = cstm_pkg::KEY_W'($urandom());
			end
		endcase
		write_reg(cstm_pkg::CFG_NODE_COUNT, cnt);
		write_reg(cstm_pkg::CFG_MOD_A_LOW, alo);
		write_reg(cstm_pkg::CFG_MOD_A_HIGH, ahi);
		write_reg(cstm_pkg::CFG_MOD_B_LOW, blo);
		write_reg(cstm_pkg::CFG_MOD_B_HIGH, bhi);
		write_reg(cstm_pkg::CFG_MOD_SINGLE_A, s1);
		write_reg(cstm_pkg::CFG_MOD_SINGLE_B, s2);
		end_writes();
	endtask

	task automatic run_phase(int size, int extra);
		cstm_pkg::item_t it;
		int r, p, at;
		pool.delete();
		foreach (in_pool[i])
			in_pool[i] = 1'b0;
		for (int i = 0; i < size; i++)
			pool.push_back(i);
		if ($urandom_range(0, 3) == 0)
			pool.push_back(cstm_pkg::NODE_DEPTH - 1);
		foreach (pool[i])
			in_pool[pool[i]] = 1'b1;
		foreach (pool[i]) begin
			it = make_node(pool[i], i);
			if (i == 0)
				it.leaf = ($urandom_range(0, 5) != 0);
			queue_item(it);
		end
		queue_item(loose_item(cstm_pkg::OP_RESET, cstm_pkg::KEY_W'($urandom())));
		repeat (extra) begin
			r = $urandom_range(0, 99);
			if (r < 68) begin
				queue_item(loose_item(cstm_pkg::OP_FEED, pick_feed_key()));
			end else if (r < 80) begin
				if ($urandom_range(0, 2) != 0) begin
					p = $urandom_range(0, pool.size() - 1);
					queue_item(make_node(pool[p], p));
				end else begin
					do at = $urandom_range(0, cstm_pkg::NODE_DEPTH - 1);
					while (in_pool[at]);
					queue_item(make_node(at, -1));
				end
			end else if (r < 95) begin
				queue_item(loose_item(cstm_pkg::OP_RESET, cstm_pkg::KEY_W'($urandom())));
			end else begin
				queue_item(loose_item(cstm_pkg::OP_NOP, cstm_pkg::KEY_W'($urandom())));
			end
		end
	endtask

	initial begin
		int phase, mode;
		cfg_nodes = 1;
		mod_a_lo = 65505;
		mod_a_hi = 65518;
		mod_b_lo = 65025;
		mod_b_hi = 65043;
		mod_one = 65406;
		mod_two = 65407;
		cur_node = '0;
		last_node = '0;
		key_base = 'h61;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single-node table, modifier, no-op
		queue_item(node_item(0, '0, 0, 0, 1'b1, 0, '0, '0));
		queue_item(loose_item(cstm_pkg::OP_FEED, 'h61));
		queue_item(loose_item(cstm_pkg::OP_FEED, 65505));
		queue_item(loose_item(cstm_pkg::OP_NOP, '0));
		wait_drained();
		write_reg(cstm_pkg::CFG_NODE_COUNT, 5);
		end_writes();
		// field extremes: keysym 0 and max, node 4095, full text and symbol
		queue_item(node_item(1, 'h6D, 2, cstm_pkg::NODE_DEPTH - 1, 1'b0, 3, '0, '0));
		queue_item(node_item(2, '0, 0, 0, 1'b1, 0, '1, KEY_MAX));
		queue_item(node_item(3, 'h6E, 0, 0, 1'b0, cstm_pkg::NODE_DEPTH - 1, '0, '0));
		queue_item(node_item(cstm_pkg::NODE_DEPTH - 1, KEY_MAX, 0, 0, 1'b1, 0, 'h1234, 'h61));
		queue_item(loose_item(cstm_pkg::OP_FEED, '0));
		queue_item(loose_item(cstm_pkg::OP_FEED, KEY_MAX));
		queue_item(loose_item(cstm_pkg::OP_FEED, 'h6D));
		queue_item(loose_item(cstm_pkg::OP_FEED, 'h6E));
		queue_item(loose_item(cstm_pkg::OP_FEED, KEY_MAX));
		queue_item(loose_item(cstm_pkg::OP_FEED, 'h6D));
		queue_item(loose_item(cstm_pkg::OP_FEED, 'h7A));
		queue_item(loose_item(cstm_pkg::OP_FEED, 'h71));
		queue_item(loose_item(cstm_pkg::OP_FEED, 65406));
		queue_item(loose_item(cstm_pkg::OP_FEED, 65043));
		queue_item(loose_item(cstm_pkg::OP_RESET, '0));
		wait_drained();
		write_reg(CFG_SPARE, 'h5A5A);
		end_writes();
		// self-linked sibling: walk runs out of steps and misses
		queue_item(node_item(2, 'h62, 2, 0, 1'b0, 0, '0, '0));
		queue_item(loose_item(cstm_pkg::OP_FEED, 'h10));
		queue_item(loose_item(cstm_pkg::OP_FEED, 'h6D));
		queue_item(loose_item(cstm_pkg::OP_RESET, '0));

		phase = 0;
		while (worth < 900) begin
			wait_drained();
			key_base = ($urandom_range(0, 2) == 0) ?
				cstm_pkg::KEY_W'($urandom_range(0, KEY_MAX - 16)) :
				cstm_pkg::KEY_W'('h61);
			if (phase < 3)
				mode = phase;
			else if ($urandom_range(0, 7) == 0)
				mode = $urandom_range(0, 2);
			else
				mode = 3;
			set_config(mode);
			if (worth > 820)
				idle_pct = 0;
			else
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 4;
					default: idle_pct = 12;
				endcase
			run_phase(($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) :
				$urandom_range(2, 16),
				(mode == 1) ? 20 : $urandom_range(40, 110));
			phase++;
		end
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
